>>> rtl/bscd_pkg.sv
// ----------------------------------------------------------------------------
// bscd_pkg: shared types and constants of the coverage density block
// Field widths, saturation limits, the control state type and the result
// record passed from the control logic to the accumulator.
// ----------------------------------------------------------------------------
package bscd_pkg;

    localparam int unsigned LenW    = 13;
    localparam int unsigned ProbW   = 24;
    localparam int unsigned OffW    = 12;
    localparam int unsigned SumW    = 25;
    localparam int unsigned CntW    = 5;
    localparam int unsigned CfgIdxW = 1;

    localparam logic [OffW-1:0]  OffMax   = {OffW{1'b1}};
    localparam logic [ProbW-1:0] CovMax   = {ProbW{1'b1}};
    localparam logic [SumW-1:0]  SumMax   = {SumW{1'b1}};
    localparam logic [CntW-1:0]  DivLast  = CntW'(ProbW - 1);

    localparam logic [LenW-1:0] MinLenRst = 13'd1;
    localparam logic [LenW-1:0] MaxLenRst = 13'd4096;

    localparam logic [CfgIdxW-1:0] CfgMinLen = 1'b0;
    localparam logic [CfgIdxW-1:0] CfgMaxLen = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_ACC
    } t_state;

    typedef struct packed {
        logic [OffW-1:0] position;
        logic [OffW-1:0] mirror_position;
    } t_offsets;

endpackage

>>> rtl/bscd_div_serial.sv
// ----------------------------------------------------------------------------
// bscd_div_serial: bit-serial restoring divider
// Shifts the dividend through a register one bit per cycle and develops one
// quotient bit per cycle against a 13-bit divisor.
// ----------------------------------------------------------------------------
module bscd_div_serial
    import bscd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [ProbW-1:0] i_dividend,
    input  logic [LenW-1:0]  i_divisor,
    output logic             o_done,
    output logic [ProbW-1:0] o_quotient
);

    logic             r_busy;
    logic             r_done;
    logic [CntW-1:0]  r_cnt;
    logic [LenW-1:0]  r_rem;
    logic [LenW-1:0]  r_dvs;
    logic [ProbW-1:0] r_quo;

    logic [LenW:0]    w_shift;
    logic [LenW+1:0]  w_diff;
    logic             w_fit;

    assign w_shift = {r_rem, r_quo[ProbW-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_dvs};
    assign w_fit   = ~w_diff[LenW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DivLast) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[LenW-1:0] : w_shift[LenW-1:0];
            r_quo <= {r_quo[ProbW-2:0], w_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> rtl/bscd_accum.sv
// ----------------------------------------------------------------------------
// bscd_accum: saturating running sum and output register
// Adds each quotient to the running sum, clearing it first on a flagged
// beat, and holds the result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module bscd_accum
    import bscd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_first,
    input  logic [ProbW-1:0]  i_addend,
    input  t_offsets          i_offsets,
    input  logic              i_tready,
    output logic              o_free,
    output logic              o_tvalid,
    output logic [47:0]       o_tdata
);

    logic [SumW-1:0]  r_sum;
    logic [SumW-1:0]  n_sum;
    logic             r_valid;
    t_offsets         r_offsets;
    logic [ProbW-1:0] r_cov;

    logic [SumW-1:0]  w_base;
    logic [SumW:0]    w_total;

    assign o_free  = ~r_valid | i_tready;
    assign w_base  = i_first ? '0 : r_sum;
    assign w_total = {1'b0, w_base} + {2'b00, i_addend};
    assign n_sum   = w_total[SumW] ? SumMax : w_total[SumW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_sum   <= n_sum;
                r_valid <= 1'b1;
            end else if (i_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_offsets <= i_offsets;
            r_cov     <= n_sum[SumW-1] ? CovMax : n_sum[ProbW-1:0];
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = {r_cov, r_offsets.mirror_position, r_offsets.position};

endmodule

>>> rtl/binding_site_coverage_density.sv
// An accepted in-range beat passes through the 24-step bit-serial divider and then
// the accumulate step to its result beat; an out-of-range length skips the divider,
// and either waits while the output register is held. Beats are taken singly:
// a beat is accepted only after the previous one has left the accumulate step.
// Reset (synchronous, active low) clears the running sum and the output beat
// and returns min_len to 1 and max_len to 4096.
// ----------------------------------------------------------------------------
// binding_site_coverage_density: fragment-length table to coverage density
// Divides each probability by its length, accumulates the quotients and
// emits the sum at the forward and mirrored offsets.
// ----------------------------------------------------------------------------
module binding_site_coverage_density
    import bscd_pkg::*;
#(
    parameter int unsigned MAX_LEN = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [LenW-1:0]    i_cfg_data,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [39:0]        s_axis_tdata,  // length[12:0], probability[36:13], zero pad
    input  logic               s_axis_tuser,  // first
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [47:0]        m_axis_tdata   // position, mirror_position, coverage
);

    t_state           r_state;
    t_state           n_state;
    logic [LenW-1:0]  r_min_len;
    logic [LenW-1:0]  r_max_len;
    logic             r_first;
    logic             r_inside;
    t_offsets         r_offsets;

    logic [LenW-1:0]  w_len;
    logic [ProbW-1:0] w_prob;
    logic             w_accept;
    logic             w_inside;
    logic [LenW-1:0]  w_pos_raw;
    logic [LenW-1:0]  w_mir_raw;
    t_offsets         w_offsets;
    logic             w_div_start;
    logic             w_div_done;
    logic [ProbW-1:0] w_quotient;
    logic             w_acc_load;
    logic             w_acc_free;

    assign w_len    = s_axis_tdata[LenW-1:0];
    assign w_prob   = s_axis_tdata[LenW+ProbW-1:LenW];
    assign w_accept = s_axis_tvalid & s_axis_tready;

    assign w_inside = (w_len != '0) && (w_len >= r_min_len) && (w_len <= r_max_len)
                      && (32'(w_len) <= 32'(MAX_LEN));

    assign w_pos_raw = (w_len == '0) ? '0 : w_len - 1'b1;
    assign w_mir_raw = (r_max_len > w_len) ? r_max_len - w_len : '0;
    assign w_offsets.position        = w_pos_raw[LenW-1] ? OffMax : w_pos_raw[OffW-1:0];
    assign w_offsets.mirror_position = w_mir_raw[LenW-1] ? OffMax : w_mir_raw[OffW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= MinLenRst;
            r_max_len <= MaxLenRst;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CfgMinLen: r_min_len <= i_cfg_data;
                CfgMaxLen: r_max_len <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_first   <= s_axis_tuser;
            r_inside  <= w_inside;
            r_offsets <= w_offsets;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_inside ? ST_DIV : ST_ACC;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                if (w_acc_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        w_div_start   = 1'b0;
        w_acc_load    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                w_div_start   = s_axis_tvalid & w_inside;
            end
            ST_ACC: begin
                w_acc_load = w_acc_free;
            end
            default: ;
        endcase
    end

    bscd_div_serial u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_prob),
        .i_divisor  (w_len),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    bscd_accum u_acc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_acc_load),
        .i_first   (r_first),
        .i_addend  (r_inside ? w_quotient : '0),
        .i_offsets (r_offsets),
        .i_tready  (m_axis_tready),
        .o_free    (w_acc_free),
        .o_tvalid  (m_axis_tvalid),
        .o_tdata   (m_axis_tdata)
    );

endmodule

>>> rtl/bscd_checker.sv
// ----------------------------------------------------------------------------
// bscd_checker: port-level checks for the coverage density block
// Watches the stream ports for one-beat-at-a-time input, output ordering
// after input, held output beats and a clean output after reset.
// ----------------------------------------------------------------------------
module bscd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("Input accepted again right after a beat was taken.");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("Result beat appeared while the block was idle.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("Stalled result beat changed or vanished.");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("Result beat valid right after reset.");

endmodule

bind binding_site_coverage_density bscd_checker u_bscd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> tb/coverage_density_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coverage_density_checker: scoreboard for the coverage density block
// Watches the register port and both streams, keeps its own copy of the
// length window and the running density, predicts each result beat and
// compares it field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module coverage_density_checker
    import bscd_pkg::*;
#(
    parameter int unsigned MAX_LEN = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [LenW-1:0]    i_cfg_data,
    input  logic               i_s_tvalid,
    input  logic               i_s_tready,
    input  logic [39:0]        i_s_tdata,
    input  logic               i_s_tuser,
    input  logic               i_m_tvalid,
    input  logic               i_m_tready,
    input  logic [47:0]        i_m_tdata,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked,
    output int                 o_saturated
);

    typedef struct packed {
        logic [ProbW-1:0] coverage;
        logic [OffW-1:0]  mirror_position;
        logic [OffW-1:0]  position;
    } density_beat_t;

    logic [LenW-1:0] min_len_q = MinLenRst;
    logic [LenW-1:0] max_len_q = MaxLenRst;
    logic [SumW-1:0] density_sum = '0;
    density_beat_t   density_q[$];

    int fail_count = 0;
    int checked    = 0;
    int saturated  = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = density_q.size();
    assign o_checked    = checked;
    assign o_saturated  = saturated;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        if (fail_count <= 20) begin
            $display("MISMATCH at %0t: %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    function automatic density_beat_t predict_density(input logic first,
                                                      input logic [LenW-1:0] len,
                                                      input logic [ProbW-1:0] prob);
        logic [SumW:0]    total;
        logic [ProbW-1:0] share;
        logic [LenW-1:0]  offset;
        density_beat_t    beat;
        if (first) begin
            density_sum = '0;
        end
        share = '0;
        if (len != 0 && len >= min_len_q && len <= max_len_q && len <= MAX_LEN) begin
            share = ProbW'(prob / len);
        end
        total = density_sum + share;
        density_sum = (total > SumMax) ? SumMax : total[SumW-1:0];

        offset = (len == 0) ? '0 : len - 1'b1;
        beat.position = (offset > OffMax) ? OffMax : offset[OffW-1:0];
        offset = (max_len_q > len) ? max_len_q - len : '0;
        beat.mirror_position = (offset > OffMax) ? OffMax : offset[OffW-1:0];
        beat.coverage = (density_sum > CovMax) ? CovMax : density_sum[ProbW-1:0];
        return beat;
    endfunction

    always @(posedge i_clk) begin
        density_beat_t got;
        density_beat_t want;
        if (!i_rst_n) begin
            min_len_q   = MinLenRst;
            max_len_q   = MaxLenRst;
            density_sum = '0;
            density_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_index == CfgMinLen) begin
                    min_len_q = i_cfg_data;
                end else if (i_cfg_index == CfgMaxLen) begin
                    max_len_q = i_cfg_data;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                density_q.push_back(predict_density(i_s_tuser, i_s_tdata[LenW-1:0],
                                                    i_s_tdata[LenW +: ProbW]));
            end
            if (i_m_tvalid && i_m_tready) begin
                got = density_beat_t'(i_m_tdata);
                checked++;
                if (got.coverage == CovMax) begin
                    saturated++;
                end
                if (density_q.size() == 0) begin
                    report_mismatch("result beat with nothing expected", got.coverage, 0);
                end else begin
                    want = density_q.pop_front();
                    if (got.position != want.position) begin
                        report_mismatch("position", got.position, want.position);
                    end
                    if (got.mirror_position != want.mirror_position) begin
                        report_mismatch("mirror_position", got.mirror_position,
                                        want.mirror_position);
                    end
                    if (got.coverage != want.coverage) begin
                        report_mismatch("coverage", got.coverage, want.coverage);
                    end
                end
            end
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for binding_site_coverage_density
// Streams directed and random fragment-length tables through the block under
// several length windows and idling patterns; the checker beside the block
// predicts every coverage beat and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;
    import bscd_pkg::*;

    localparam int unsigned MaxLen    = 4096;
    localparam int          Period    = 12;
    localparam int          Limit     = 600000;
    localparam int          ItemCount = 700;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [LenW-1:0]    cfg_data = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [39:0]        s_tdata = '0;
    logic               s_tuser = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [47:0]        m_tdata;

    int fail_count;
    int pending;
    int checked;
    int saturated;
    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int cycle_count = 0;
    int sent = 0;
    int settings = 0;
    logic [LenW-1:0] cur_min = MinLenRst;
    logic [LenW-1:0] cur_max = MaxLenRst;

    binding_site_coverage_density #(
        .MAX_LEN(MaxLen)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .s_axis_tvalid(s_tvalid),
        .s_axis_tready(s_tready),
        .s_axis_tdata (s_tdata),
        .s_axis_tuser (s_tuser),
        .m_axis_tvalid(m_tvalid),
        .m_axis_tready(m_tready),
        .m_axis_tdata (m_tdata)
    );

    coverage_density_checker #(
        .MAX_LEN(MaxLen)
    ) checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_saturated (saturated)
    );

    always #(Period / 2) i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= Limit) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending);
            $display("** binding_site_coverage_density: FAILED **");
            $finish;
        end
    end

    task automatic send_beat(input logic first, input logic [LenW-1:0] len,
                             input logic [ProbW-1:0] prob);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= first;
        s_tdata  <= {3'b000, prob, len};
        @(posedge i_clk);
        while (!s_tready) begin
            @(posedge i_clk);
        end
        sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic set_lengths(input logic [LenW-1:0] min_len, input logic [LenW-1:0] max_len);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_index <= CfgMinLen;
        cfg_data  <= min_len;
        @(negedge i_clk);
        cfg_index <= CfgMaxLen;
        cfg_data  <= max_len;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
        cur_min = min_len;
        cur_max = max_len;
        settings++;
    endtask

    function automatic logic [ProbW-1:0] rand_prob();
        case ($urandom_range(0, 3))
            0: return CovMax;
            1: return ProbW'($urandom_range(0, 255));
            default: return ProbW'($urandom());
        endcase
    endfunction

    function automatic logic [LenW-1:0] rand_length();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return LenW'($urandom_range(4097, 8191));
            2: return LenW'($urandom_range(1, 4096));
            default: return LenW'($urandom_range(1, 64));
        endcase
    endfunction

    task automatic random_phase(input int n_items);
        int done;
        int steps;
        logic first;
        logic [LenW-1:0] start;
        done = 0;
        while (done < n_items) begin
            if ($urandom_range(0, 99) < 15) begin
                send_beat(1'($urandom_range(0, 1)), rand_length(), rand_prob());
                done++;
            end else begin
                start = (cur_max == 0) ? LenW'(1) : cur_max;
                steps = (start > 40) ? $urandom_range(8, 40) : int'(start);
                if ($urandom_range(0, 9) == 0) begin
                    steps = $urandom_range(1, steps);
                end
                first = ($urandom_range(0, 9) != 0);
                for (int k = 0; k < steps && done < n_items; k++) begin
                    send_beat(first && k == 0, start - LenW'(k), rand_prob());
                    done++;
                end
            end
        end
    endtask

    initial begin
        int phase;
        logic [LenW-1:0] new_max;
        logic [LenW-1:0] new_min;
        phase = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_beat(1'b1, 13'd4096, CovMax);
        send_beat(1'b0, 13'd4095, '0);
        send_beat(1'b0, 13'd0, CovMax);
        send_beat(1'b0, 13'd8191, CovMax);
        send_beat(1'b0, 13'd4097, CovMax);
        send_beat(1'b0, 13'd1, CovMax);
        send_beat(1'b0, 13'd1, CovMax);
        send_beat(1'b0, 13'd1, CovMax);
        send_beat(1'b1, 13'd2, CovMax);
        send_beat(1'b0, 13'd1, 24'd1);

        set_lengths(13'd0, 13'd8191);
        send_beat(1'b1, 13'd5000, CovMax);
        send_beat(1'b0, 13'd4096, CovMax);
        send_beat(1'b0, 13'd1, 24'h800000);

        set_lengths(13'd10, 13'd5);
        send_beat(1'b1, 13'd7, CovMax);
        send_beat(1'b0, 13'd3, CovMax);

        set_lengths(13'd3, 13'd6);
        for (int len = 6; len >= 1; len--) begin
            send_beat(len == 6, LenW'(len), CovMax);
        end

        while (sent < ItemCount) begin
            case ($urandom_range(0, 7))
                4: begin
                    new_max = 13'd4096;
                    new_min = LenW'($urandom_range(4000, 4096));
                end
                5: begin
                    new_max = 13'd1;
                    new_min = LenW'($urandom_range(0, 1));
                end
                6: begin
                    new_max = LenW'($urandom_range(0, 8191));
                    new_min = LenW'($urandom_range(0, 8191));
                end
                7: begin
                    new_max = LenW'($urandom_range(1, 40));
                    new_min = '0;
                end
                default: begin
                    new_max = LenW'($urandom_range(1, 40));
                    new_min = LenW'($urandom_range(0, new_max + 2));
                end
            endcase
            set_lengths(new_min, new_max);
            case (phase % 4)
                0: begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
                1: begin
                    src_idle_pct  = 68;
                    snk_stall_pct = 0;
                end
                2: begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 68;
                end
                default: begin
                    src_idle_pct  = 12;
                    snk_stall_pct = 12;
                end
            endcase
            phase++;
            random_phase($urandom_range(30, 60));
        end

        drain_results();
        repeat (40) @(negedge i_clk);
        $display("Sent %0d table beats under %0d length windows; %0d coverage beats checked.",
                 sent, settings, checked);
        $display("%0d of those beats carried the saturated coverage value.", saturated);
        if (fail_count == 0) begin
            $display("** binding_site_coverage_density: PASSED **");
        end else begin
            $display("** binding_site_coverage_density: FAILED **");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/bscd_pkg.sv
rtl/bscd_div_serial.sv
rtl/bscd_accum.sv
rtl/binding_site_coverage_density.sv
rtl/bscd_checker.sv
tb/coverage_density_checker.sv
tb/testbench.sv
